// File: rtl/sscd_pkg.sv
package sscd_pkg;

  // Field and datapath widths, all derived from the coordinate and fraction widths
  localparam int CW  = 32;          // coordinate width, signed
  localparam int FB  = 16;          // fraction bits of the contact time
  localparam int WW  = CW + 1;      // motion vector component
  localparam int PRW = 2 * WW;      // one signed square or dot term
  localparam int MW  = PRW + 2;     // sum of three terms
  localparam int HW  = MW / 2;      // half word for split multipliers
  localparam int PW  = 2 * MW;      // wide product
  localparam int DW  = PW + 1;      // signed discriminant
  localparam int QW  = MW + FB;     // square root width
  localparam int KW  = 2 * QW;      // scaled radicand
  localparam int RW  = QW + 3;      // root remainder
  localparam int NW  = QW + 2;      // signed numerator
  localparam int TW  = FB + 1;      // contact time

  // Outcome codes
  localparam logic [1:0] OUT_APART   = 2'd0;
  localparam logic [1:0] OUT_NO_ROOT = 2'd1;
  localparam logic [1:0] OUT_OUTSIDE = 2'd2;
  localparam logic [1:0] OUT_HIT     = 2'd3;

  // Quadratic terms leaving the front end
  typedef struct packed {
    logic          apart;
    logic          a_zero;
    logic          h_pos;
    logic          c_neg;
    logic [MW-1:0] h_mag;
    logic [MW-1:0] a_val;
    logic [MW-1:0] c_mag;
  } quad_t;

  // Item data carried alongside the root pipeline
  typedef struct packed {
    logic          calc;
    logic [1:0]    outcome;
    logic [MW-1:0] h_mag;
    logic [MW-1:0] a_val;
  } side_t;

  // One stage of the digit-by-digit square root
  typedef struct packed {
    logic [KW-1:0] rad;
    logic [RW-1:0] rem;
    logic [QW-1:0] root;
  } sq_t;

  // One stage of the restoring divider
  typedef struct packed {
    logic [QW:0]   rem;
    logic [MW-1:0] a;
    logic [TW-1:0] t;
    logic          full;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s);
    logic [RW+1:0] rem_in;
    logic [RW+1:0] trial;
    sq_t           n;
    rem_in = {s.rem, s.rad[KW-1 -: 2]};
    trial  = {3'b000, s.root, 2'b01};
    n.rad  = s.rad << 2;
    if (rem_in >= trial) begin
      n.rem  = RW'(rem_in - trial);
      n.root = {s.root[QW-2:0], 1'b1};
    end else begin
      n.rem  = RW'(rem_in);
      n.root = {s.root[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  // Quotient bit k; once the top bit is set the time is full scale
  function automatic dv_t div_step(input dv_t s, input int unsigned k);
    logic [QW:0] shd;
    dv_t         n;
    shd = (QW + 1)'(s.a) << k;
    n   = s;
    if (!s.full && (s.rem >= shd)) begin
      n.rem  = s.rem - shd;
      n.t    = s.t | (TW'(1) << k);
      n.full = (k == FB);
    end
    return n;
  endfunction

endpackage

// File: rtl/sscd_front.sv
module sscd_front import sscd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] cur [3],
  input  logic signed [CW-1:0] old [3],
  input  logic [CW-2:0]        rad_a,
  input  logic [CW-2:0]        rad_b,
  output logic                 out_valid,
  output quad_t                quad
);

  logic signed [CW-1:0]  cur_r [3];
  logic signed [CW-1:0]  old_r [3];
  logic signed [WW-1:0]  w_r [3];
  logic [CW-1:0]         rs_r;
  logic signed [PRW-1:0] cc_p_r [3];
  logic signed [PRW-1:0] aa_p_r [3];
  logic signed [PRW-1:0] hh_p_r [3];
  logic signed [PRW-1:0] pp_p_r [3];
  logic [2*CW-1:0]       r2_r;
  logic [2*CW-1:0]       r2b_r;
  logic signed [MW-1:0]  a_r, h_r, pp_r, cc_r;
  logic signed [MW-1:0]  r2s, c_w;
  quad_t                 quad_r;
  logic [3:0]            vld_r;

  // Stage 1: motion vector and radius sum
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cur_r[i] <= cur[i];
      old_r[i] <= old[i];
      w_r[i]   <= WW'(cur[i]) - WW'(old[i]);
    end
    rs_r <= CW'(rad_a) + CW'(rad_b);
  end

  // Stage 2: component products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cc_p_r[i] <= PRW'(cur_r[i]) * PRW'(cur_r[i]);
      aa_p_r[i] <= PRW'(w_r[i]) * PRW'(w_r[i]);
      hh_p_r[i] <= PRW'(old_r[i]) * PRW'(w_r[i]);
      pp_p_r[i] <= PRW'(old_r[i]) * PRW'(old_r[i]);
    end
    r2_r <= (2 * CW)'(rs_r) * (2 * CW)'(rs_r);
  end

  // Stage 3: dot products
  always_ff @(posedge clk) begin
    a_r   <= MW'(aa_p_r[0]) + MW'(aa_p_r[1]) + MW'(aa_p_r[2]);
    h_r   <= MW'(hh_p_r[0]) + MW'(hh_p_r[1]) + MW'(hh_p_r[2]);
    pp_r  <= MW'(pp_p_r[0]) + MW'(pp_p_r[1]) + MW'(pp_p_r[2]);
    cc_r  <= MW'(cc_p_r[0]) + MW'(cc_p_r[1]) + MW'(cc_p_r[2]);
    r2b_r <= r2_r;
  end

  // Stage 4: apart test, constant term and magnitudes
  assign r2s = MW'(r2b_r);
  assign c_w = pp_r - r2s;

  always_ff @(posedge clk) begin
    quad_r.apart  <= cc_r > r2s;
    quad_r.a_zero <= a_r == '0;
    quad_r.h_pos  <= !h_r[MW-1] && (h_r != '0);
    quad_r.c_neg  <= c_w[MW-1];
    quad_r.h_mag  <= h_r[MW-1] ? MW'(-h_r) : MW'(h_r);
    quad_r.a_val  <= MW'(a_r);
    quad_r.c_mag  <= c_w[MW-1] ? MW'(-c_w) : MW'(c_w);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  assign out_valid = vld_r[3];
  assign quad      = quad_r;

endmodule

// File: rtl/sscd_wmul.sv
module sscd_wmul import sscd_pkg::*; (
  input  logic          clk,
  input  logic [MW-1:0] x,
  input  logic [MW-1:0] y,
  output logic [PW-1:0] p
);

  logic [2*HW-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [PW-1:0]   p_r;

  // Partial products on half words
  always_ff @(posedge clk) begin
    ll_r <= (2 * HW)'(x[HW-1:0]) * (2 * HW)'(y[HW-1:0]);
    lh_r <= (2 * HW)'(x[HW-1:0]) * (2 * HW)'(y[MW-1:HW]);
    hl_r <= (2 * HW)'(x[MW-1:HW]) * (2 * HW)'(y[HW-1:0]);
    hh_r <= (2 * HW)'(x[MW-1:HW]) * (2 * HW)'(y[MW-1:HW]);
  end

  // Recombine
  always_ff @(posedge clk) begin
    p_r <= PW'(ll_r) + (PW'(lh_r) << HW) + (PW'(hl_r) << HW) + (PW'(hh_r) << (2 * HW));
  end

  assign p = p_r;

endmodule

// File: rtl/sscd_sqrt.sv
module sscd_sqrt import sscd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [KW-1:0] rad,
  input  side_t         side_in,
  output logic          out_valid,
  output logic [QW-1:0] root,
  output logic          exact,
  output side_t         side_out
);

  sq_t   st_r  [QW];
  side_t sd_r  [QW];
  logic  vld_r [QW];

  // One root bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    sq_t   prev;
    side_t prev_sd;
    logic  prev_v;

    if (k == 0) begin : g_first
      assign prev    = '{rad: rad, rem: '0, root: '0};
      assign prev_sd = side_in;
      assign prev_v  = in_valid;
    end else begin : g_next
      assign prev    = st_r[k-1];
      assign prev_sd = sd_r[k-1];
      assign prev_v  = vld_r[k-1];
    end

    always_ff @(posedge clk) begin
      st_r[k] <= sqrt_step(prev);
      sd_r[k] <= prev_sd;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= prev_v;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign root      = st_r[QW-1].root;
  assign exact     = st_r[QW-1].rem == '0;
  assign side_out  = sd_r[QW-1];

endmodule

// File: rtl/sscd_div.sv
module sscd_div import sscd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [QW:0]   num,
  input  logic [MW-1:0] den,
  input  logic          calc_in,
  input  logic [1:0]    outcome_in,
  output logic          out_valid,
  output logic [TW-1:0] t,
  output logic          calc_out,
  output logic [1:0]    outcome_out
);

  dv_t        st_r   [TW];
  logic       calc_r [TW];
  logic [1:0] oc_r   [TW];
  logic       vld_r  [TW];

  // Quotient bits from full scale down, one per stage
  for (genvar j = 0; j < TW; j++) begin : g_stage
    dv_t        prev;
    logic       prev_calc;
    logic [1:0] prev_oc;
    logic       prev_v;

    if (j == 0) begin : g_first
      assign prev      = '{rem: num, a: den, t: '0, full: 1'b0};
      assign prev_calc = calc_in;
      assign prev_oc   = outcome_in;
      assign prev_v    = in_valid;
    end else begin : g_next
      assign prev      = st_r[j-1];
      assign prev_calc = calc_r[j-1];
      assign prev_oc   = oc_r[j-1];
      assign prev_v    = vld_r[j-1];
    end

    always_ff @(posedge clk) begin
      st_r[j]   <= div_step(prev, FB - j);
      calc_r[j] <= prev_calc;
      oc_r[j]   <= prev_oc;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= prev_v;
      end
    end
  end

  assign out_valid   = vld_r[TW-1];
  assign t           = st_r[TW-1].t;
  assign calc_out    = calc_r[TW-1];
  assign outcome_out = oc_r[TW-1];

endmodule

// File: rtl/swept_sphere_contact_test.sv
// Swept sphere-sphere contact test.
// Input channel: an item (current and previous centre offsets, both radii)
// is taken on a rising edge with start high and busy low. busy is always
// low, so one item can be taken every clock cycle.
// Result channel: out_valid is high for one cycle with out_outcome and
// out_contact_time; the receiver takes it at the end of that cycle and
// cannot hold it off.
// The pipeline holds four front-end stages for the dot products, two
// for the split wide multipliers, one for the discriminant, one stage
// per root bit of the square root (QW = 2*CW + 4 + FB), one for the
// numerator, one per time bit in the divider and the output register.
// Throughput is one item per cycle; items leave in the order they
// arrive.
// Reset clears the valid bits of every stage; items in flight are dropped
// and no result appears until a new item has passed through.
module swept_sphere_contact_test import sscd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_cur_dx,
  input  logic signed [CW-1:0] in_cur_dy,
  input  logic signed [CW-1:0] in_cur_dz,
  input  logic signed [CW-1:0] in_old_dx,
  input  logic signed [CW-1:0] in_old_dy,
  input  logic signed [CW-1:0] in_old_dz,
  input  logic [CW-2:0]        in_radius_a,
  input  logic [CW-2:0]        in_radius_b,
  output logic                 out_valid,
  output logic [1:0]           out_outcome,
  output logic [TW-1:0]        out_contact_time
);

  logic signed [CW-1:0] cur_w [3];
  logic signed [CW-1:0] old_w [3];
  logic                 accept;
  logic                 fv;
  quad_t                quad;
  logic [PW-1:0]        h2, ac;
  quad_t                q5_r, q6_r;
  logic                 v5_r, v6_r;
  logic signed [DW-1:0] d_w;
  side_t                side_nxt;
  side_t                side7_r;
  logic [KW-1:0]        rad7_r;
  logic                 v7_r;
  logic                 sv;
  logic [QW-1:0]        root;
  logic                 exact;
  side_t                sside;
  logic [QW:0]          q_w;
  logic signed [NW-1:0] n_w;
  logic [QW:0]          num8_r;
  logic [MW-1:0]        a8_r;
  logic                 calc8_r;
  logic [1:0]           oc8_r;
  logic                 v8_r;
  logic                 dv;
  logic [TW-1:0]        t;
  logic                 dcalc;
  logic [1:0]           doc;
  logic                 out_valid_r;
  logic [1:0]           out_outcome_r;
  logic [TW-1:0]        out_time_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign cur_w[0] = in_cur_dx;
  assign cur_w[1] = in_cur_dy;
  assign cur_w[2] = in_cur_dz;
  assign old_w[0] = in_old_dx;
  assign old_w[1] = in_old_dy;
  assign old_w[2] = in_old_dz;

  sscd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .cur       (cur_w),
    .old       (old_w),
    .rad_a     (in_radius_a),
    .rad_b     (in_radius_b),
    .out_valid (fv),
    .quad      (quad)
  );

  // h^2 and a*|c|
  sscd_wmul u_mul_hh (.clk(clk), .x(quad.h_mag), .y(quad.h_mag), .p(h2));
  sscd_wmul u_mul_ac (.clk(clk), .x(quad.a_val), .y(quad.c_mag), .p(ac));

  // Terms follow the multipliers
  always_ff @(posedge clk) begin
    q5_r <= quad;
    q6_r <= q5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v5_r <= fv;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= sv;
    end
  end

  // Discriminant and classification
  assign d_w = q6_r.c_neg ? DW'(DW'(h2) + DW'(ac)) : DW'(DW'(h2) - DW'(ac));

  always_comb begin
    side_nxt.calc    = 1'b0;
    side_nxt.h_mag   = q6_r.h_mag;
    side_nxt.a_val   = q6_r.a_val;
    if (q6_r.apart) begin
      side_nxt.outcome = OUT_APART;
    end else if (q6_r.a_zero) begin
      side_nxt.outcome = OUT_HIT;
    end else if (d_w[DW-1]) begin
      side_nxt.outcome = OUT_NO_ROOT;
    end else if (!q6_r.h_pos && !q6_r.c_neg) begin
      side_nxt.outcome = OUT_HIT;
      side_nxt.calc    = 1'b1;
    end else begin
      side_nxt.outcome = OUT_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    side7_r <= side_nxt;
    rad7_r  <= d_w[DW-1] ? '0 : {d_w[PW-1:0], (2 * FB)'(0)};
  end

  sscd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .rad       (rad7_r),
    .side_in   (side7_r),
    .out_valid (sv),
    .root      (root),
    .exact     (exact),
    .side_out  (sside)
  );

  // Numerator: -h scaled minus the rounded-up root, floored at zero
  assign q_w = (QW + 1)'(root) + (QW + 1)'(!exact);
  assign n_w = NW'({sside.h_mag, FB'(0)}) - NW'(q_w);

  always_ff @(posedge clk) begin
    num8_r  <= n_w[NW-1] ? '0 : n_w[QW:0];
    a8_r    <= sside.a_val;
    calc8_r <= sside.calc;
    oc8_r   <= sside.outcome;
  end

  sscd_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v8_r),
    .num         (num8_r),
    .den         (a8_r),
    .calc_in     (calc8_r),
    .outcome_in  (oc8_r),
    .out_valid   (dv),
    .t           (t),
    .calc_out    (dcalc),
    .outcome_out (doc)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    out_outcome_r <= doc;
    out_time_r    <= dcalc ? t : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_contact_time = out_time_r;

endmodule
